FILE: design/grid_quadratic_interpolator_top_defines.svh
// Assertion macros for the grid interpolator.
// Used by grid_quadratic_interpolator_top; needs clk and rst_n in scope.
`ifndef GRID_QUADRATIC_INTERPOLATOR_TOP_DEFINES_SVH
`define GRID_QUADRATIC_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define GQI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gqi assertion failed");

// next-cycle implication
`define GQI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gqi assertion failed");

`endif

FILE: design/gqi_pkg.sv
// Types, codes and helpers for the grid interpolator.
// No dependencies.
package gqi_pkg;

  localparam int POINTS    = 64;
  localparam int ADDR_W    = $clog2(POINTS);
  localparam int PC_W      = 7;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 96;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_QUERY = 1'b1;
  localparam logic [1:0] ST_QUAD  = 2'd0;
  localparam logic [1:0] ST_LIN   = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [5:0]         point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } gqi_in_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic [1:0]         status;
  } gqi_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } gqi_point_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } gqi_alu_op_t;

  typedef struct packed {
    logic        start;
    gqi_alu_op_t op;
    logic [95:0] opa;
    logic [63:0] opb;
  } gqi_alu_req_t;

  typedef struct packed {
    logic        done;
    logic [96:0] result;
  } gqi_alu_rsp_t;

  function automatic logic [31:0] mag33(logic signed [32:0] v);
    logic [32:0] u;
    u = v[32] ? 33'(-v) : 33'(v);
    return u[31:0];
  endfunction

endpackage

FILE: design/grid_quadratic_interpolator_top.sv
// Grid interpolator top: query sequencer, grid store and shared ALU.
// Depends on gqi_pkg, gqi_grid_mem, gqi_alu and the defines header.
//
//   channel  | ports                        | request taken when
//   input    | start, busy, in_req          | start & !busy
//   result   | out_strobe, out_result       | out_strobe (one cycle)
//   config   | cfg_valid, cfg_ready, cfg_data | cfg_valid & cfg_ready
//
// A grid write does not make the block busy. A query clamped at an end
// returns early; an interpolated query runs a binary search, then per term
// three multiplies, a divide and one accumulate (one term for linear, three
// for quadratic), then saturates. The result strobe follows in the first
// idle cycle.
// Reset is synchronous; grid contents are undefined until written.
// The receiver cannot stall; busy is high for the whole query.
`include "grid_quadratic_interpolator_top_defines.svh"

module grid_quadratic_interpolator_top import gqi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  gqi_in_t         in_req,
  output logic            out_strobe,
  output gqi_out_t        out_result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [PC_W-1:0] cfg_data
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_RD0    = 16'h0002,
    S_CHK0   = 16'h0004,
    S_CHKN   = 16'h0008,
    S_SMID   = 16'h0010,
    S_SCM    = 16'h0020,
    S_SCN    = 16'h0040,
    S_LD     = 16'h0080,
    S_LA     = 16'h0100,
    S_LB     = 16'h0200,
    S_LC     = 16'h0400,
    S_CZ     = 16'h0800,
    S_LAUNCH = 16'h1000,
    S_WAIT   = 16'h2000,
    S_ACC    = 16'h4000,
    S_SAT    = 16'h8000
  } state_t;

  localparam logic signed [99:0] SUM_MAX = 100'sd2147483647;
  localparam logic signed [99:0] SUM_MIN = -100'sd2147483648;

  state_t             state_r, state_nxt;
  logic [PC_W-1:0]    pcount_r, pcount_nxt;
  logic               strobe_r, strobe_nxt;
  gqi_out_t           res_r, res_nxt;
  logic signed [31:0] t_r, t_nxt;
  logic [5:0]         nm1_r, nm1_nxt, nm1_c;
  logic signed [7:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid_sum;
  logic [5:0]         mid_r, mid_nxt, mid_c, k_r, k_nxt;
  logic signed [31:0] xm_r, xm_nxt;
  gqi_point_t         pa_r, pa_nxt, pb_r, pb_nxt, pc_r, pc_nxt;
  logic               lin_r, lin_nxt;
  logic [1:0]         term_r, term_nxt, ph_r, ph_nxt;
  logic [63:0]        p_r, p_nxt, d_r, d_nxt;
  logic [95:0]        n_r, n_nxt;
  logic signed [99:0] sum_r, sum_nxt;

  logic               accept;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_raddr;
  gqi_point_t         mem_wdata, rd;
  gqi_alu_req_t       alu_req;
  gqi_alu_rsp_t       alu_rsp;

  logic signed [32:0] ta, tb, tc, d01, d02, d12, dyl, dx;
  logic signed [32:0] op_y, op_a, op_b, op_m1, op_m2;
  logic               dneg, tneg;
  logic [99:0]        qext;
  logic signed [31:0] sat_y;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign mem_we    = accept && (in_req.operation == OP_WRITE);
  assign mem_wdata = '{x: in_req.x_value, y: in_req.y_value};

  gqi_grid_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ADDR_W'(in_req.point_index)),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  gqi_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  always_comb begin
    if (pcount_r < PC_W'(2)) begin
      nm1_c = 6'd1;
    end else if (pcount_r > PC_W'(POINTS)) begin
      nm1_c = 6'(POINTS - 1);
    end else begin
      nm1_c = 6'(pcount_r - PC_W'(1));
    end
  end

  assign mid_sum = lo_r + hi_r;
  assign mid_c   = mid_sum[6:1];

  always_comb begin
    mem_raddr = '0;
    unique case (state_r)
      S_CHK0:  mem_raddr = ADDR_W'(nm1_r);
      S_SMID:  mem_raddr = ADDR_W'(mid_c);
      S_SCM:   mem_raddr = ADDR_W'(mid_r + 6'd1);
      S_LD:    mem_raddr = ADDR_W'(k_r - 6'd1);
      S_LA:    mem_raddr = ADDR_W'(k_r);
      S_LB:    mem_raddr = ADDR_W'(k_r + 6'd1);
      default: mem_raddr = '0;
    endcase
  end

  // operand differences
  assign ta  = {t_r[31], t_r} - {pa_r.x[31], pa_r.x};
  assign tb  = {t_r[31], t_r} - {pb_r.x[31], pb_r.x};
  assign tc  = {t_r[31], t_r} - {pc_r.x[31], pc_r.x};
  assign d01 = {pa_r.x[31], pa_r.x} - {pb_r.x[31], pb_r.x};
  assign d02 = {pa_r.x[31], pa_r.x} - {pc_r.x[31], pc_r.x};
  assign d12 = {pb_r.x[31], pb_r.x} - {pc_r.x[31], pc_r.x};
  assign dyl = {pc_r.y[31], pc_r.y} - {pb_r.y[31], pb_r.y};
  assign dx  = {pc_r.x[31], pc_r.x} - {pb_r.x[31], pb_r.x};

  always_comb begin
    op_y  = dyl;
    op_a  = tb;
    op_b  = 33'sd1;
    op_m1 = dx;
    op_m2 = 33'sd1;
    dneg  = dx[32];
    if (!lin_r) begin
      unique case (term_r)
        2'd0: begin
          op_y  = {pa_r.y[31], pa_r.y};
          op_a  = tb;
          op_b  = tc;
          op_m1 = d01;
          op_m2 = d02;
          dneg  = d01[32] ^ d02[32];
        end
        2'd1: begin
          op_y  = {pb_r.y[31], pb_r.y};
          op_a  = ta;
          op_b  = tc;
          op_m1 = d01;
          op_m2 = d12;
          dneg  = ~d01[32] ^ d12[32];
        end
        default: begin
          op_y  = {pc_r.y[31], pc_r.y};
          op_a  = ta;
          op_b  = tb;
          op_m1 = d02;
          op_m2 = d12;
          dneg  = d02[32] ^ d12[32];
        end
      endcase
    end
    tneg = op_y[32] ^ op_a[32] ^ op_b[32] ^ dneg;
  end

  always_comb begin
    alu_req.start = (state_r == S_LAUNCH);
    alu_req.op    = ALU_MUL;
    alu_req.opa   = 96'(mag33(op_a));
    alu_req.opb   = 64'(mag33(op_b));
    unique case (ph_r)
      2'd0: ;
      2'd1: begin
        alu_req.opa = 96'(mag33(op_m1));
        alu_req.opb = 64'(mag33(op_m2));
      end
      2'd2: begin
        alu_req.opa = {32'd0, p_r};
        alu_req.opb = 64'(mag33(op_y));
      end
      default: begin
        alu_req.op  = ALU_DIV;
        alu_req.opa = n_r;
        alu_req.opb = d_r;
      end
    endcase
  end

  assign qext = {3'b000, alu_rsp.result};

  always_comb begin
    if (sum_r > SUM_MAX) begin
      sat_y = 32'sh7FFFFFFF;
    end else if (sum_r < SUM_MIN) begin
      sat_y = 32'sh80000000;
    end else begin
      sat_y = sum_r[31:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pcount_nxt = pcount_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    t_nxt      = t_r;
    nm1_nxt    = nm1_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    k_nxt      = k_r;
    xm_nxt     = xm_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    pc_nxt     = pc_r;
    lin_nxt    = lin_r;
    term_nxt   = term_r;
    ph_nxt     = ph_r;
    p_nxt      = p_r;
    d_nxt      = d_r;
    n_nxt      = n_r;
    sum_nxt    = sum_r;
    if (cfg_valid && cfg_ready) begin
      pcount_nxt = cfg_data;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_req.operation == OP_QUERY)) begin
          t_nxt     = in_req.x_value;
          nm1_nxt   = nm1_c;
          state_nxt = S_RD0;
        end
      end
      S_RD0: state_nxt = S_CHK0;
      S_CHK0: begin
        if (t_r <= rd.x) begin
          strobe_nxt = 1'b1;
          res_nxt    = '{result_y: rd.y, status: ST_CLAMP};
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_CHKN;
        end
      end
      S_CHKN: begin
        if (t_r >= rd.x) begin
          strobe_nxt = 1'b1;
          res_nxt    = '{result_y: rd.y, status: ST_CLAMP};
          state_nxt  = S_IDLE;
        end else begin
          lo_nxt    = 8'sd0;
          hi_nxt    = $signed({2'b00, nm1_r});
          state_nxt = S_SMID;
        end
      end
      S_SMID: begin
        if (lo_r > hi_r) begin
          strobe_nxt = 1'b1;
          res_nxt    = '{result_y: 32'sd0, status: ST_ERR};
          state_nxt  = S_IDLE;
        end else begin
          mid_nxt   = mid_c;
          state_nxt = S_SCM;
        end
      end
      S_SCM: begin
        xm_nxt = rd.x;
        if (mid_r < nm1_r) begin
          state_nxt = S_SCN;
        end else begin
          if (rd.x < t_r) begin
            lo_nxt = $signed({2'b00, mid_r} + 8'd1);
          end else begin
            hi_nxt = $signed({2'b00, mid_r} - 8'd1);
          end
          state_nxt = S_SMID;
        end
      end
      S_SCN: begin
        if ((xm_r <= t_r) && (t_r <= rd.x)) begin
          k_nxt     = mid_r;
          lin_nxt   = (mid_r == 6'd0) || (mid_r == (nm1_r - 6'd1));
          state_nxt = S_LD;
        end else begin
          if (xm_r < t_r) begin
            lo_nxt = $signed({2'b00, mid_r} + 8'd1);
          end else begin
            hi_nxt = $signed({2'b00, mid_r} - 8'd1);
          end
          state_nxt = S_SMID;
        end
      end
      S_LD: state_nxt = S_LA;
      S_LA: begin
        pa_nxt    = rd;
        state_nxt = S_LB;
      end
      S_LB: begin
        pb_nxt    = rd;
        state_nxt = S_LC;
      end
      S_LC: begin
        pc_nxt    = rd;
        state_nxt = S_CZ;
      end
      S_CZ: begin
        if (lin_r ? (dx == 33'sd0)
                  : ((d01 == 33'sd0) || (d02 == 33'sd0) || (d12 == 33'sd0))) begin
          strobe_nxt = 1'b1;
          res_nxt    = '{result_y: 32'sd0, status: ST_ERR};
          state_nxt  = S_IDLE;
        end else begin
          sum_nxt   = lin_r ? 100'(pb_r.y) : 100'sd0;
          term_nxt  = 2'd0;
          ph_nxt    = 2'd0;
          state_nxt = S_LAUNCH;
        end
      end
      S_LAUNCH: state_nxt = S_WAIT;
      S_WAIT: begin
        if (alu_rsp.done) begin
          unique case (ph_r)
            2'd0:    p_nxt = alu_rsp.result[63:0];
            2'd1:    d_nxt = alu_rsp.result[63:0];
            2'd2:    n_nxt = alu_rsp.result[95:0];
            default: ;
          endcase
          if (ph_r == 2'd3) begin
            state_nxt = S_ACC;
          end else begin
            ph_nxt    = ph_r + 2'd1;
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_ACC: begin
        sum_nxt = tneg ? (sum_r - $signed(qext)) : (sum_r + $signed(qext));
        if (lin_r || (term_r == 2'd2)) begin
          state_nxt = S_SAT;
        end else begin
          term_nxt  = term_r + 2'd1;
          ph_nxt    = 2'd0;
          state_nxt = S_LAUNCH;
        end
      end
      S_SAT: begin
        strobe_nxt = 1'b1;
        res_nxt    = '{result_y: sat_y, status: (lin_r ? ST_LIN : ST_QUAD)};
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pcount_r <= PC_W'(POINTS);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pcount_r <= pcount_nxt;
      strobe_r <= strobe_nxt;
    end
    res_r  <= res_nxt;
    t_r    <= t_nxt;
    nm1_r  <= nm1_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    k_r    <= k_nxt;
    xm_r   <= xm_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    pc_r   <= pc_nxt;
    lin_r  <= lin_nxt;
    term_r <= term_nxt;
    ph_r   <= ph_nxt;
    p_r    <= p_nxt;
    d_r    <= d_nxt;
    n_r    <= n_nxt;
    sum_r  <= sum_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_result = res_r;

  `GQI_ASSERT_NOW(a_strobe_idle, out_strobe, !busy)
  `GQI_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)
  `GQI_ASSERT_NEXT(a_query_busy, accept && (in_req.operation == OP_QUERY), busy)
  `GQI_ASSERT_NOW(a_alu_start_idle, alu_req.start, state_r == S_LAUNCH && !alu_rsp.done)

endmodule

FILE: design/gqi_grid_mem.sv
// Grid point store: one write port, one registered read port.
// Depends on gqi_pkg.
module gqi_grid_mem import gqi_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  gqi_point_t        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output gqi_point_t        rdata
);

  gqi_point_t mem [POINTS];
  gqi_point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/gqi_alu.sv
// Shared arithmetic unit: shift-add multiply (64 x 32) and restoring
// divide (96 / 64) with round half away. Depends on gqi_pkg.
module gqi_alu import gqi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  gqi_alu_req_t req,
  output gqi_alu_rsp_t rsp
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_RND  = 4'b1000
  } alu_state_t;

  alu_state_t  st_r, st_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [96:0] acc_r, acc_nxt;
  logic [95:0] sh_r, sh_nxt;
  logic [63:0] mr_r, mr_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic        done_r, done_nxt;
  logic [64:0] rem_sh;
  logic [65:0] rem_sub;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mr_nxt   = mr_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[63:0], sh_r[95]};
    rem_sub  = {1'b0, rem_sh} - {2'b00, mr_r};
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          rem_nxt = '0;
          sh_nxt  = req.opa;
          mr_nxt  = req.opb;
          st_nxt  = (req.op == ALU_MUL) ? A_MUL : A_DIV;
        end
      end
      A_MUL: begin
        if (mr_r[0]) begin
          acc_nxt = acc_r + {1'b0, sh_r};
        end
        sh_nxt  = {sh_r[94:0], 1'b0};
        mr_nxt  = {1'b0, mr_r[63:1]};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(MUL_STEPS - 1)) begin
          st_nxt   = A_IDLE;
          done_nxt = 1'b1;
        end
      end
      A_DIV: begin
        sh_nxt  = {sh_r[94:0], 1'b0};
        rem_nxt = rem_sub[65] ? rem_sh : rem_sub[64:0];
        acc_nxt = {acc_r[95:0], ~rem_sub[65]};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          st_nxt = A_RND;
        end
      end
      A_RND: begin
        if ({rem_r[63:0], 1'b0} >= {1'b0, mr_r}) begin
          acc_nxt = acc_r + 97'd1;
        end
        st_nxt   = A_IDLE;
        done_nxt = 1'b1;
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mr_r  <= mr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule
